/* rtl/bvd_pkg.sv */
// Shared types and constants for the batched vector distance unit.
// Used by bvd_lane, bvd_merge and batched_vector_distance_4_unit; depends on nothing.
package bvd_pkg;

	// Field widths of the streamed elements and of the results.
	localparam int DIN_W         = 16;
	localparam int MAG_W         = 16;
	localparam int TERM_W        = 32;
	localparam int DIST_W        = 47;
	localparam int CNT_W         = 13;
	localparam int NUM_CAND      = 4;
	localparam int DIM_FIELD_MAX = 8191;

	// Defaults for the top-level parameters.
	localparam int MAX_DIM_DEF = 4096;
	localparam int LANES_DEF   = 4;

	// Metric selected by the configuration register.
	typedef enum logic {
		METRIC_SQ_EUCLID  = 1'b0,
		METRIC_MANHATTAN  = 1'b1
	} metric_t;

	// Per-cycle pipeline control shared by all lanes and the merge stage.
	typedef struct packed {
		logic load;   // an element moves from the input stage into the term stage
		logic acc;    // the term stage element is added into the accumulators
		logic clear;  // that element is the last one: emit and clear
	} lane_ctl_t;

endpackage

/* rtl/bvd_lane.sv */
// One distance lane: difference, metric term and saturating accumulator.
// Depends on bvd_pkg.
module bvd_lane import bvd_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  lane_ctl_t                ctl,
	input  metric_t                  mode_s1,
	input  logic signed [DIN_W-1:0]  query_s1,
	input  logic signed [DIN_W-1:0]  cand_s1,
	output logic [DIST_W-1:0]        sum
);

	logic signed [DIN_W:0]  diff;
	logic [MAG_W-1:0]       mag;
	logic [TERM_W-1:0]      term;
	logic [TERM_W-1:0]      term_s2;
	logic [DIST_W-1:0]      acc_q;
	logic [DIST_W:0]        sum_wide;

	// Exact 17-bit difference and its magnitude, which always fits in 16 bits.
	always_comb begin
		diff = {query_s1[DIN_W-1], query_s1} - {cand_s1[DIN_W-1], cand_s1};
		if (diff[DIN_W]) begin
			mag = MAG_W'(-diff);
		end else begin
			mag = MAG_W'(diff);
		end
		if (mode_s1 == METRIC_MANHATTAN) begin
			term = TERM_W'(mag);
		end else begin
			term = TERM_W'(mag) * TERM_W'(mag);
		end
	end

	// Term register between the multiplier and the accumulator.
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			term_s2 <= term;
		end
	end

	// Saturating sum; the accumulator never exceeds the field maximum.
	always_comb begin
		sum_wide = {1'b0, acc_q} + (DIST_W + 1)'(term_s2);
		if (sum_wide[DIST_W]) begin
			sum = '1;
		end else begin
			sum = sum_wide[DIST_W-1:0];
		end
	end

	// Accumulator, cleared once the last element has been folded in.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (ctl.acc) begin
			acc_q <= ctl.clear ? '0 : sum;
		end
	end

endmodule

/* rtl/bvd_merge.sv */
// Merge stage: element counter and the output register that gathers all lanes.
// Depends on bvd_pkg.
module bvd_merge import bvd_pkg::*; #(
	parameter int MAX_DIM = MAX_DIM_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  lane_ctl_t          ctl,
	input  logic [DIST_W-1:0]  lane_sum [NUM_CAND],
	input  logic               out_ready,
	output logic               out_valid,
	output logic [DIST_W-1:0]  dist_out [NUM_CAND],
	output logic [CNT_W-1:0]   dims_seen
);

	localparam int CntCap = (MAX_DIM < DIM_FIELD_MAX) ? MAX_DIM : DIM_FIELD_MAX;

	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_next;
	logic             out_valid_q;
	logic [DIST_W-1:0] dist_q [NUM_CAND];
	logic [CNT_W-1:0] dims_q;

	// Element count including the element being accumulated, saturating.
	always_comb begin
		if (count_q < CNT_W'(CntCap)) begin
			count_next = count_q + CNT_W'(1);
		end else begin
			count_next = count_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctl.acc) begin
			count_q <= ctl.clear ? '0 : count_next;
		end
	end

	// Output valid: set by a last element, dropped when the beat is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.acc && ctl.clear) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output payload, loaded with the final sums of every lane.
	always_ff @(posedge clk) begin
		if (ctl.acc && ctl.clear) begin
			dist_q  <= lane_sum;
			dims_q  <= count_next;
		end
	end

	assign out_valid = out_valid_q;
	assign dist_out  = dist_q;
	assign dims_seen = dims_q;

endmodule

/* rtl/batched_vector_distance_4_unit.sv */
// Top level of the four-lane streaming distance unit.
// Depends on bvd_pkg, bvd_lane and bvd_merge.
//
// Usage:
// Input channel (in_valid/in_ready) carries one beat per vector dimension:
// the query element, the matching element of four candidates (signed Q8.8)
// and last_elem marking the final dimension. Configuration channel
// (cfg_valid/cfg_ready, data metric_mode) selects squared Euclidean (0) or
// Manhattan (1); cfg_ready is always high. The user makes writes only while
// idle; the unit does not enforce this. Output channel (out_valid/out_ready)
// carries one beat per vector: four saturated distances and the element
// count. Throughput: one input beat per cycle unless the pipeline stalls,
// set by the accumulator add in each lane. The result of a last beat passes
// the input register, the multiply stage and the accumulate into the output
// register before it is presented.
// Reset clears the accumulators, the count, the metric (to squared
// Euclidean) and all valid flags. When the receiver stalls, the result waits
// in the output register and input beats keep flowing until the next last
// beat reaches the accumulate stage; only then does in_ready drop.
module batched_vector_distance_4_unit import bvd_pkg::*; #(
	parameter int MAX_DIM = MAX_DIM_DEF,
	parameter int LANES   = LANES_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic                     metric_mode,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic signed [DIN_W-1:0]  query_elem,
	input  logic signed [DIN_W-1:0]  cand0_elem,
	input  logic signed [DIN_W-1:0]  cand1_elem,
	input  logic signed [DIN_W-1:0]  cand2_elem,
	input  logic signed [DIN_W-1:0]  cand3_elem,
	input  logic                     last_elem,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [DIST_W-1:0]        dist0,
	output logic [DIST_W-1:0]        dist1,
	output logic [DIST_W-1:0]        dist2,
	output logic [DIST_W-1:0]        dist3,
	output logic [CNT_W-1:0]         dims_seen
);

	localparam int CntCap = (MAX_DIM < DIM_FIELD_MAX) ? MAX_DIM : DIM_FIELD_MAX;

	metric_t                 mode_q;
	logic                    adv;
	logic                    valid_s1;
	logic                    last_s1;
	metric_t                 mode_s1;
	logic signed [DIN_W-1:0] query_s1;
	logic signed [DIN_W-1:0] cand_s1 [NUM_CAND];
	logic                    valid_s2;
	logic                    last_s2;
	lane_ctl_t               ctl;
	logic [DIST_W-1:0]       lane_sum [NUM_CAND];
	logic [DIST_W-1:0]       dist_vec [NUM_CAND];

	// Metric register.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= METRIC_SQ_EUCLID;
		end else if (cfg_valid && cfg_ready) begin
			mode_q <= metric_t'(metric_mode);
		end
	end

	// The pipeline stalls only when a last element would overwrite a result
	// that is still waiting in the output register.
	assign adv      = !(valid_s2 && last_s2 && out_valid && !out_ready);
	assign in_ready = adv;

	always_comb begin
		ctl.load  = adv && valid_s1;
		ctl.acc   = adv && valid_s2;
		ctl.clear = last_s2;
	end

	// Valid flags of the input and term stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	// Input stage payload.
	always_ff @(posedge clk) begin
		if (adv && in_valid) begin
			query_s1   <= query_elem;
			cand_s1[0] <= cand0_elem;
			cand_s1[1] <= cand1_elem;
			cand_s1[2] <= cand2_elem;
			cand_s1[3] <= cand3_elem;
			last_s1    <= last_elem;
			mode_s1    <= mode_q;
		end
	end

	// Last mark travels alongside the lane term registers.
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			last_s2 <= last_s1;
		end
	end

	// Lanes: active ones accumulate, the rest report zero.
	for (genvar i = 0; i < NUM_CAND; i++) begin : g_lane
		if (i < LANES) begin : g_on
			bvd_lane u_lane (
				.clk      (clk),
				.arst_n   (arst_n),
				.ctl      (ctl),
				.mode_s1  (mode_s1),
				.query_s1 (query_s1),
				.cand_s1  (cand_s1[i]),
				.sum      (lane_sum[i])
			);
		end else begin : g_off
			assign lane_sum[i] = '0;
		end
	end

	// Merge stage with the element counter and output register.
	bvd_merge #(
		.MAX_DIM (MAX_DIM)
	) u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.lane_sum  (lane_sum),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.dist_out  (dist_vec),
		.dims_seen (dims_seen)
	);

	assign dist0 = dist_vec[0];
	assign dist1 = dist_vec[1];
	assign dist2 = dist_vec[2];
	assign dist3 = dist_vec[3];

	// A result always counts at least the last element.
	a_dims_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> dims_seen != '0)
		else $error("result with zero element count");

	// The element count never passes its cap.
	a_dims_cap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> dims_seen <= CNT_W'(CntCap))
		else $error("element count above cap");

	// Input is held back only by a waiting result.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled without a waiting result");

	// Lane 3, when beyond the configured count, stays at zero.
	a_idle_lane: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (LANES > 3) || (dist3 == '0))
		else $error("disabled lane reports a distance");

	// A last element in the accumulate stage produces a result next cycle.
	a_emit: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.acc && ctl.clear |=> out_valid)
		else $error("last element did not produce a result");

endmodule

/* test/batched_vector_distance_4_unit_tb.sv */
// Self-checking testbench for batched_vector_distance_4_unit: random and directed vectors,
// a per-beat distance predictor and a scoreboard of expected result beats.
// Depends on bvd_pkg and the RTL of the unit; reads no files.
module batched_vector_distance_4_unit_tb;
	import bvd_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int QUIET_LIMIT = 400;
	localparam int CNT_CAP = (MAX_DIM_DEF < DIM_FIELD_MAX) ? MAX_DIM_DEF : DIM_FIELD_MAX;
	localparam logic [DIST_W:0] SUM_MAX = {1'b0, {DIST_W{1'b1}}};

	// One element beat: the query, the four candidates and the end-of-vector mark.
	typedef struct packed {
		logic [DIN_W-1:0] q;
		logic [NUM_CAND-1:0][DIN_W-1:0] cand;
		logic is_last;
	} elem_t;

	// One result beat: four distances and the element count.
	typedef struct packed {
		logic [NUM_CAND-1:0][DIST_W-1:0] lane_dist;
		logic [CNT_W-1:0] dims;
	} dist_beat_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic metric_mode = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [DIN_W-1:0] query_elem;
	logic signed [DIN_W-1:0] cand0_elem;
	logic signed [DIN_W-1:0] cand1_elem;
	logic signed [DIN_W-1:0] cand2_elem;
	logic signed [DIN_W-1:0] cand3_elem;
	logic last_elem;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [DIST_W-1:0] dist0;
	logic [DIST_W-1:0] dist1;
	logic [DIST_W-1:0] dist2;
	logic [DIST_W-1:0] dist3;
	logic [CNT_W-1:0] dims_seen;

	elem_t elem_queue[$];
	dist_beat_t dist_expected[$];
	elem_t drv_elem = '0;

	// Predictor state, a copy of what the unit keeps.
	logic [DIST_W-1:0] lane_sum[NUM_CAND] = '{default: '0};
	int unsigned dims_count = 0;
	metric_t cur_metric = METRIC_SQ_EUCLID;

	bit in_beat = 1'b0;
	bit out_beat = 1'b0;
	bit in_calm = 1'b0;
	bit out_calm = 1'b0;
	int in_gap = 0;
	int out_hold = 0;
	int quiet = 0;
	int errors = 0;

	assign query_elem = drv_elem.q;
	assign cand0_elem = drv_elem.cand[0];
	assign cand1_elem = drv_elem.cand[1];
	assign cand2_elem = drv_elem.cand[2];
	assign cand3_elem = drv_elem.cand[3];
	assign last_elem = drv_elem.is_last;

	batched_vector_distance_4_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.metric_mode(metric_mode),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.query_elem(query_elem),
		.cand0_elem(cand0_elem),
		.cand1_elem(cand1_elem),
		.cand2_elem(cand2_elem),
		.cand3_elem(cand3_elem),
		.last_elem(last_elem),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.dist0(dist0),
		.dist1(dist1),
		.dist2(dist2),
		.dist3(dist3),
		.dims_seen(dims_seen)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	task automatic flag_mismatch(string what);
		$display("ERROR @%0t: %s", $realtime, what);
		errors++;
	endtask

	// Sample the handshakes, update the predictor and score result beats.
	always @(posedge clk) begin
		logic [DIN_W:0] diff;
		logic [DIN_W:0] mag;
		logic [TERM_W-1:0] term;
		logic [DIST_W:0] sum;
		dist_beat_t want;
		logic [DIST_W-1:0] got[NUM_CAND];
		bit cfg_beat;
		if (arst_n) begin
			cfg_beat = cfg_valid && cfg_ready;
			in_beat = in_valid && in_ready;
			out_beat = out_valid && out_ready;
			if (cfg_beat) begin
				cur_metric = metric_t'(metric_mode);
			end

			// Each lane adds the squared or absolute difference, saturating.
			if (in_beat) begin
				for (int i = 0; i < NUM_CAND; i++) begin
					diff = {drv_elem.q[DIN_W-1], drv_elem.q}
						- {drv_elem.cand[i][DIN_W-1], drv_elem.cand[i]};
					mag = diff[DIN_W] ? (~diff + 1'b1) : diff;
					if (cur_metric == METRIC_MANHATTAN) begin
						term = TERM_W'(mag);
					end else begin
						term = TERM_W'(mag) * TERM_W'(mag);
					end
					sum = {1'b0, lane_sum[i]} + (DIST_W + 1)'(term);
					lane_sum[i] = (sum > SUM_MAX) ? SUM_MAX[DIST_W-1:0] : sum[DIST_W-1:0];
				end
				if (dims_count < CNT_CAP) begin
					dims_count++;
				end
				if (drv_elem.is_last) begin
					for (int i = 0; i < NUM_CAND; i++) begin
						want.lane_dist[i] = lane_sum[i];
						lane_sum[i] = '0;
					end
					want.dims = CNT_W'(dims_count);
					dims_count = 0;
					dist_expected.push_back(want);
				end
			end

			// Compare each result beat with the oldest expectation.
			if (out_beat) begin
				if (dist_expected.size() == 0) begin
					flag_mismatch("result beat arrived with none expected");
				end else begin
					want = dist_expected.pop_front();
					got = '{dist0, dist1, dist2, dist3};
					for (int i = 0; i < NUM_CAND; i++) begin
						if (got[i] !== want.lane_dist[i]) begin
							flag_mismatch($sformatf("dist%0d got %0d expected %0d",
								i, got[i], want.lane_dist[i]));
						end
					end
					if (dims_seen !== want.dims) begin
						flag_mismatch($sformatf("dims_seen got %0d expected %0d",
							dims_seen, want.dims));
					end
				end
			end

			// Watchdog on cycles without any handshake.
			if (cfg_beat || in_beat || out_beat) begin
				quiet = 0;
			end else begin
				quiet++;
			end
			if (quiet >= QUIET_LIMIT) begin
				$display("FAIL batched_vector_distance_4_unit");
				$finish;
			end
		end
	end

	// Element driver: holds each beat until accepted, then idles a drawn number of cycles.
	always @(negedge clk) begin
		if (arst_n && (!in_valid || in_beat)) begin
			if (in_gap != 0) begin
				in_valid <= 1'b0;
				in_gap--;
			end else if (elem_queue.size() != 0) begin
				drv_elem = elem_queue.pop_front();
				in_valid <= 1'b1;
				if ($urandom_range(0, 39) == 0) begin
					in_calm = !in_calm;
				end
				in_gap = in_calm ? 0 : $urandom_range(0, 11);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Result receiver: stalls a drawn number of cycles after each beat.
	always @(negedge clk) begin
		if (out_beat) begin
			if ($urandom_range(0, 39) == 0) begin
				out_calm = !out_calm;
			end
			out_hold = out_calm ? 0 : $urandom_range(0, 11);
		end
		if (out_hold != 0) begin
			out_ready <= 1'b0;
			out_hold--;
		end else begin
			out_ready <= 1'b1;
		end
	end

	task automatic write_metric(metric_t m);
		@(negedge clk);
		cfg_valid <= 1'b1;
		metric_mode <= m;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
		#1;
	endtask

	// Wait until every element is taken and every result has come, then let the pipeline drain.
	task automatic settle();
		do begin
			@(posedge clk);
			#1;
		end while (elem_queue.size() != 0 || in_valid || dist_expected.size() != 0);
		repeat (6) @(posedge clk);
		#1;
	endtask

	task automatic push_elem(logic [DIN_W-1:0] q, logic [DIN_W-1:0] c0, logic [DIN_W-1:0] c1,
			logic [DIN_W-1:0] c2, logic [DIN_W-1:0] c3, bit is_last);
		elem_t e;
		e.q = q;
		e.cand = {c3, c2, c1, c0};
		e.is_last = is_last;
		elem_queue.push_back(e);
	endtask

	// Element values biased toward the extremes and small numbers.
	function automatic logic [DIN_W-1:0] rand_sample();
		case ($urandom_range(0, 7))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'h0000;
			3: return DIN_W'($urandom_range(0, 511) - 256);
			default: return DIN_W'($urandom);
		endcase
	endfunction

	// A vector of random content; an open vector carries no end mark.
	task automatic push_vector(int len, bit closed);
		logic [DIN_W-1:0] q;
		logic [DIN_W-1:0] c[NUM_CAND];
		for (int k = 0; k < len; k++) begin
			q = rand_sample();
			for (int i = 0; i < NUM_CAND; i++) begin
				c[i] = ($urandom_range(0, 7) == 0) ? q : rand_sample();
			end
			push_elem(q, c[0], c[1], c[2], c[3], closed && (k == len - 1));
		end
	endtask

	initial begin
		int n;
		int len;
		int pick;
		metric_t m;

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		#1;

		// Directed: extreme differences, zero distances, a short vector, then
		// vectors that span a metric change.
		write_metric(METRIC_SQ_EUCLID);
		push_elem(16'h7FFF, 16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 1'b1);
		push_elem(16'h8000, 16'h7FFF, 16'h8000, 16'h0001, 16'h0100, 1'b1);
		push_elem(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1);
		push_elem(16'h0100, 16'hFF00, 16'h0080, 16'h0100, 16'h5555, 1'b0);
		push_elem(16'hAAAA, 16'h5555, 16'hAAAA, 16'h0001, 16'hFFFF, 1'b0);
		push_elem(16'h1234, 16'hEDCC, 16'h1234, 16'h8000, 16'h7FFF, 1'b1);
		push_elem(16'h7FFF, 16'h8000, 16'h0000, 16'h7FFF, 16'hC000, 1'b0);
		push_elem(16'h8000, 16'h7FFF, 16'h4000, 16'h8000, 16'h0000, 1'b0);
		settle();
		write_metric(METRIC_MANHATTAN);
		push_elem(16'h0001, 16'hFFFF, 16'h0002, 16'h0001, 16'h8000, 1'b1);
		push_elem(16'h7FFF, 16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 1'b1);
		push_elem(16'h8000, 16'h7FFF, 16'h8000, 16'hFFFF, 16'h0001, 1'b1);
		push_elem(16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 16'h0000, 1'b0);
		push_elem(16'hFFFF, 16'h0000, 16'h7FFF, 16'h8000, 16'hFFFF, 1'b0);
		settle();
		write_metric(METRIC_SQ_EUCLID);
		push_elem(16'h8000, 16'h7FFF, 16'h0000, 16'h8000, 16'h7FFF, 1'b1);
		settle();

		// A longer vector with the largest difference on lane 0 throughout.
		for (int k = 0; k < 200; k++) begin
			push_elem(16'h7FFF, 16'h8000, DIN_W'($urandom), 16'h7FFF, 16'h0000, k == 199);
		end
		settle();

		// Random phases, each ending in an open vector that the next metric continues.
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: m = METRIC_MANHATTAN;
				1: m = METRIC_SQ_EUCLID;
				default: m = metric_t'($urandom_range(0, 1));
			endcase
			write_metric(m);
			n = 0;
			while (n < 300) begin
				pick = $urandom_range(0, 19);
				if (pick < 14) begin
					len = $urandom_range(1, 8);
				end else if (pick < 19) begin
					len = $urandom_range(9, 40);
				end else begin
					len = $urandom_range(41, 200);
				end
				push_vector(len, 1'b1);
				n += len;
			end
			push_vector($urandom_range(1, 5), 1'b0);
			settle();
		end

		if (errors == 0) begin
			$display("PASS batched_vector_distance_4_unit");
		end else begin
			$display("FAIL batched_vector_distance_4_unit");
		end
		$finish;
	end

endmodule

/* batched_vector_distance_4_unit.f */
rtl/bvd_pkg.sv
rtl/bvd_lane.sv
rtl/bvd_merge.sv
rtl/batched_vector_distance_4_unit.sv
test/batched_vector_distance_4_unit_tb.sv
